[sv/dwc_pkg.sv]
// Shared types and constants for the deferred write coalescer.
// No dependencies; imported by dwc_slot_ram, deferred_write_coalescer and tb_top.
`default_nettype none

package dwc_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam logic [15:0] QUIET_RESET = 16'd4000;

    // request codes
    localparam logic [1:0] REQ_SAVE  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    // result kinds
    localparam logic RK_WRITE  = 1'b0;
    localparam logic RK_STATUS = 1'b1;

    // save outcomes
    localparam logic [1:0] SAVE_UPDATED = 2'd0;
    localparam logic [1:0] SAVE_ALLOC   = 2'd1;
    localparam logic [1:0] SAVE_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        now_ms;
        logic [7:0]         ns_id;
        logic [7:0]         key_id;
        logic               value_kind;
        logic signed [31:0] data_value;
    } cmd_t;

    typedef struct packed {
        logic               result_kind;
        logic [1:0]         save_status;
        logic [7:0]         out_ns_id;
        logic [7:0]         out_key_id;
        logic               out_kind;
        logic signed [31:0] out_value;
        logic               last_result;
    } result_t;

    // one slot as held in the slot RAM
    typedef struct packed {
        logic [7:0]         ns_id;
        logic [7:0]         key_id;
        logic               kind;
        logic signed [31:0] value;
        logic [31:0]        stamp;
    } slot_entry_t;

endpackage

`default_nettype wire

[sv/dwc_slot_ram.sv]
// Slot storage RAM: one write port, one read port, registered read data.
// Depends on dwc_pkg (slot_entry_t).
`default_nettype none

module dwc_slot_ram
    import dwc_pkg::*;
#(
    parameter int DEPTH  = NUM_SLOTS_DEF,
    parameter int ADDR_W = 3
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire slot_entry_t       wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output slot_entry_t            rd_data
);

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[sv/deferred_write_coalescer.sv]
// Deferred write coalescer top: slot table that batches setting saves and releases
// them as store writes on tick or flush; depends on dwc_pkg and dwc_slot_ram.
// Save/tick/flush: busy through the scan (slot RAM read one slot per cycle, registered
// read data) and the done state that writes back; no new word is taken while busy.
// Results at most one per cycle; the last is on the ports in the first cycle busy is
// low. Code 3 is dropped with no result. Reset: used/pending clear, quiet 4000 ms.
`default_nettype none

module deferred_write_coalescer
    import dwc_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command word
    input  wire logic        start,
    output logic             busy,
    input  wire cmd_t        cmd,
    // result words, one-cycle strobe
    output logic             result_strobe,
    output result_t          result,
    // quiet period register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_SLOTS);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]           state_reg,       state_next;
    cmd_t                 cmd_reg,         cmd_next;
    logic [15:0]          quiet_reg,       quiet_next;
    logic [NUM_SLOTS-1:0] slot_used_reg,   slot_used_next;
    logic [NUM_SLOTS-1:0] slot_pending_reg, slot_pending_next;
    logic [CNT_W-1:0]     rd_cnt_reg,      rd_cnt_next;
    logic                 cmp_vld_reg,     cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg,     cmp_idx_next;
    logic                 hit_found_reg,   hit_found_next;
    logic [IDX_W-1:0]     hit_idx_reg,     hit_idx_next;
    logic                 free_found_reg,  free_found_next;
    logic [IDX_W-1:0]     free_idx_reg,    free_idx_next;
    logic                 held_vld_reg,    held_vld_next;
    result_t              held_reg,        held_next;
    logic                 res_vld_reg,     res_vld_next;
    result_t              res_reg,         res_next;

    logic        issue;
    logic        mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_entry_t mem_wdata;
    slot_entry_t rd_entry;
    logic [31:0] age;
    logic        due;
    logic        is_save;

    // one slot read per cycle while the scan runs
    assign issue   = (state_reg == ST_SCAN) && (rd_cnt_reg < CNT_END);
    assign is_save = (cmd_reg.req_type == REQ_SAVE);

    // wrapping age of the slot under compare
    assign age = cmd_reg.now_ms - rd_entry.stamp;
    assign due = slot_pending_reg[cmp_idx_reg]
                 && ((cmd_reg.req_type == REQ_FLUSH) || (age > {16'd0, quiet_reg}));

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        quiet_next        = quiet_reg;
        slot_used_next    = slot_used_reg;
        slot_pending_next = slot_pending_reg;
        rd_cnt_next       = rd_cnt_reg;
        cmp_vld_next      = issue;
        cmp_idx_next      = rd_cnt_reg[IDX_W-1:0];
        hit_found_next    = hit_found_reg;
        hit_idx_next      = hit_idx_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        held_vld_next     = held_vld_reg;
        held_next         = held_reg;
        res_vld_next      = 1'b0;
        res_next          = res_reg;
        mem_we            = 1'b0;
        mem_waddr         = hit_idx_reg;
        mem_wdata.ns_id   = cmd_reg.ns_id;
        mem_wdata.key_id  = cmd_reg.key_id;
        mem_wdata.kind    = cmd_reg.value_kind;
        mem_wdata.value   = cmd_reg.data_value;
        mem_wdata.stamp   = cmd_reg.now_ms;

        if (cfg_valid)
        begin
            quiet_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    if ((cmd.req_type == REQ_SAVE) || (cmd.req_type == REQ_TICK)
                        || (cmd.req_type == REQ_FLUSH))
                    begin
                        state_next      = ST_SCAN;
                        rd_cnt_next     = '0;
                        hit_found_next  = 1'b0;
                        free_found_next = 1'b0;
                        held_vld_next   = 1'b0;
                    end
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    if (is_save)
                    begin
                        // first matching used slot wins; also note first free one
                        if (slot_used_reg[cmp_idx_reg])
                        begin
                            if (!hit_found_reg && (rd_entry.ns_id == cmd_reg.ns_id)
                                && (rd_entry.key_id == cmd_reg.key_id))
                            begin
                                hit_found_next = 1'b1;
                                hit_idx_next   = cmp_idx_reg;
                            end
                        end
                        else if (!free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                    end
                    else if (due)
                    begin
                        // hold one write back so the last one can be flagged
                        slot_pending_next[cmp_idx_reg] = 1'b0;
                        if (held_vld_reg)
                        begin
                            res_vld_next = 1'b1;
                            res_next     = held_reg;
                        end
                        held_vld_next         = 1'b1;
                        held_next.result_kind = RK_WRITE;
                        held_next.save_status = SAVE_UPDATED;
                        held_next.out_ns_id   = rd_entry.ns_id;
                        held_next.out_key_id  = rd_entry.key_id;
                        held_next.out_kind    = rd_entry.kind;
                        held_next.out_value   = rd_entry.value;
                        held_next.last_result = 1'b0;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
                if (is_save)
                begin
                    res_vld_next         = 1'b1;
                    res_next             = '0;
                    res_next.result_kind = RK_STATUS;
                    res_next.last_result = 1'b1;
                    if (hit_found_reg)
                    begin
                        res_next.save_status = SAVE_UPDATED;
                        mem_we               = 1'b1;
                        mem_waddr            = hit_idx_reg;
                        slot_pending_next[hit_idx_reg] = 1'b1;
                    end
                    else if (free_found_reg)
                    begin
                        res_next.save_status = SAVE_ALLOC;
                        mem_we               = 1'b1;
                        mem_waddr            = free_idx_reg;
                        slot_used_next[free_idx_reg]    = 1'b1;
                        slot_pending_next[free_idx_reg] = 1'b1;
                    end
                    else
                    begin
                        res_next.save_status = SAVE_FULL;
                    end
                end
                else if (held_vld_reg)
                begin
                    res_vld_next         = 1'b1;
                    res_next             = held_reg;
                    res_next.last_result = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            quiet_reg        <= QUIET_RESET;
            slot_used_reg    <= '0;
            slot_pending_reg <= '0;
            rd_cnt_reg       <= '0;
            cmp_vld_reg      <= 1'b0;
            hit_found_reg    <= 1'b0;
            free_found_reg   <= 1'b0;
            held_vld_reg     <= 1'b0;
            res_vld_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            quiet_reg        <= quiet_next;
            slot_used_reg    <= slot_used_next;
            slot_pending_reg <= slot_pending_next;
            rd_cnt_reg       <= rd_cnt_next;
            cmp_vld_reg      <= cmp_vld_next;
            hit_found_reg    <= hit_found_next;
            free_found_reg   <= free_found_next;
            held_vld_reg     <= held_vld_next;
            res_vld_reg      <= res_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        held_reg     <= held_next;
        res_reg      <= res_next;
    end

    dwc_slot_ram #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (issue),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_strobe = res_vld_reg;
    assign result        = res_reg;

    // a slot can only be pending once it has been claimed
    a_pending_used: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_pending_reg & ~slot_used_reg) == '0)
        else $error("pending bit set on unused slot");

    // compare stage is empty outside the scan
    a_cmp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |-> !cmp_vld_reg)
        else $error("compare stage active outside scan");

    // a status word is always the only, hence last, word of its save
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (result.result_kind == RK_STATUS)) |-> result.last_result)
        else $error("status word without last flag");

    // nothing follows the last word of an item in the next cycle
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last_result) |=> !result_strobe)
        else $error("word right after last word");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Testbench for deferred_write_coalescer: directed and randomized command words checked
// against a slot-table predictor held inside the bench.
// Depends on dwc_pkg and the RTL of deferred_write_coalescer.
`default_nettype none

module tb_top;
    import dwc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = NUM_SLOTS_DEF;
    // busy covers the whole scan and the last write trails it; pad a bit
    localparam int SETTLE = SLOTS + 6;
    localparam int RANDOM_ITEMS = 180;

    // request code the block ignores
    localparam logic [1:0] REQ_NONE = 2'd3;

    // ------------------------------------------------------------------
    // clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    cmd_t        cmd = '0;
    logic        result_strobe;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    deferred_write_coalescer #(
        .NUM_SLOTS (SLOTS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // stimulus queue: command words and quiet-period writes, in order
    // ------------------------------------------------------------------
    typedef struct {
        bit          is_cfg;
        bit          drain;     // hold off until every expected word is back
        int          gap;       // idle cycles before this word goes out
        cmd_t        word;
        logic [15:0] cfg_word;
    } stim_t;

    stim_t stim_q[$];
    bit    burst_mode;          // zero-gap stretch when set

    // the eight setting ids that end up owning the table
    logic [7:0] pool_ns  [SLOTS] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA};
    logic [7:0] pool_key [SLOTS] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h02, 8'h40, 8'hAA, 8'h55};

    task automatic add_cmd(input logic [1:0] req, input logic [31:0] now,
                           input logic [7:0] ns, input logic [7:0] key,
                           input logic kind, input logic [31:0] val, input bit drain);
        stim_t s;
        begin
            s.is_cfg          = 1'b0;
            s.drain           = drain;
            s.gap             = burst_mode ? 0 : $urandom_range(0, 4);
            s.word.req_type   = req;
            s.word.now_ms     = now;
            s.word.ns_id      = ns;
            s.word.key_id     = key;
            s.word.value_kind = kind;
            s.word.data_value = val;
            s.cfg_word        = '0;
            stim_q.push_back(s);
        end
    endtask

    // register writes only go out on an idle block, so they always drain
    task automatic add_cfg(input logic [15:0] q);
        stim_t s;
        begin
            s.is_cfg   = 1'b1;
            s.drain    = 1'b1;
            s.gap      = $urandom_range(0, 4);
            s.word     = '0;
            s.cfg_word = q;
            stim_q.push_back(s);
        end
    endtask

    // Directed part. Runs first on the reset quiet period of 4000 ms, with
    // stamps just below the 32-bit wrap so the age math wraps too.
    task automatic build_directed();
        logic [31:0] t0;
        logic [31:0] t;
        begin
            t0 = 32'hFFFF_F830;
            burst_mode = 1'b0;
            // empty table: tick and flush release nothing, code 3 is dropped
            add_cmd(REQ_TICK,  t0, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0);
            add_cmd(REQ_FLUSH, t0, 8'hFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
            add_cmd(REQ_NONE,  32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
            // allocate two, then update the first
            add_cmd(REQ_SAVE, t0, pool_ns[0], pool_key[0], 1'b0, 32'h7FFF_FFFF, 1'b0);
            add_cmd(REQ_SAVE, t0, pool_ns[1], pool_key[1], 1'b1, 32'h8000_0000, 1'b0);
            add_cmd(REQ_SAVE, t0 + 32'd10, pool_ns[0], pool_key[0], 1'b1,
                    32'hFFFF_FFFF, 1'b0);
            // age equal to the quiet period holds, one more releases
            add_cmd(REQ_TICK, t0 + 32'd4000, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0);
            add_cmd(REQ_TICK, t0 + 32'd4001, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0);
            add_cmd(REQ_TICK, t0 + 32'd4010, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0);
            add_cmd(REQ_TICK, t0 + 32'd4011, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0);
            // fill the rest of the table, then one save too many
            t = t0 + 32'd5000;
            for (int i = 2; i < SLOTS; i++)
                add_cmd(REQ_SAVE, t, pool_ns[i], pool_key[i], i[0],
                        {8'($urandom_range(0, 255)), 24'h00_00A5} ^ 32'(i), 1'b0);
            add_cmd(REQ_SAVE, t, 8'h07, 8'h07, 1'b1, 32'h1234_5678, 1'b0);
            // flush everything pending, then flush an already clean table
            add_cmd(REQ_FLUSH, t, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0);
            add_cmd(REQ_FLUSH, t, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0);
            add_cmd(REQ_SAVE, t, pool_ns[1], pool_key[1], 1'b0, 32'h0, 1'b0);
            add_cmd(REQ_SAVE, t, pool_ns[0], pool_key[0], 1'b1, 32'h1, 1'b0);
            add_cmd(REQ_FLUSH, t, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0);
            // zero quiet period: age 0 holds, age 1 releases
            add_cfg(16'd0);
            t = t0 + 32'd9000;
            add_cmd(REQ_SAVE, t, pool_ns[4], pool_key[4], 1'b0, 32'h0000_00FF, 1'b0);
            add_cmd(REQ_TICK, t, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0);
            add_cmd(REQ_TICK, t + 32'd1, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0);
            // longest quiet period
            add_cfg(16'hFFFF);
            add_cmd(REQ_SAVE, t, pool_ns[5], pool_key[5], 1'b1, 32'hDEAD_BEEF, 1'b0);
            add_cmd(REQ_TICK, t + 32'd65535, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0);
            add_cmd(REQ_TICK, t + 32'd65536, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0);
        end
    endtask

    // Random part: phases on different quiet periods. The table is full of
    // the pool ids by now, so most saves update and release later; the rest
    // are strangers that hit the full table.
    task automatic build_random();
        logic [15:0] q;
        logic [31:0] now;
        logic [31:0] val;
        logic [7:0]  ns;
        logic [7:0]  key;
        int          counted;
        int          phase;
        int          r;
        int          p;
        begin
            now = $urandom();
            counted = 0;
            phase = 0;
            while (counted < RANDOM_ITEMS)
            begin
                if (counted >= phase * (RANDOM_ITEMS / 6))
                begin
                    case (phase % 6)
                        0: q = 16'($urandom_range(1, 15));
                        1: q = 16'hFFFF;
                        2: q = 16'd0;
                        3: q = 16'($urandom_range(0, 65535));
                        4: q = QUIET_RESET;
                        default: q = 16'($urandom_range(100, 2000));
                    endcase
                    add_cfg(q);
                    phase++;
                end
                if ($urandom_range(0, 11) == 0)
                    burst_mode = ($urandom_range(0, 3) == 0);
                now = now + $urandom_range(0, q / 3 + 3);
                val = ($urandom_range(0, 9) == 0)
                      ? (($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                      : $urandom();
                p = $urandom_range(0, SLOTS - 1);
                r = $urandom_range(0, 99);
                if (r < 45)
                    add_cmd(REQ_SAVE, now, pool_ns[p], pool_key[p],
                            1'($urandom_range(0, 1)), val, $urandom_range(0, 32) == 0);
                else if (r < 55)
                begin
                    ns  = 8'($urandom_range(0, 255));
                    key = 8'($urandom_range(0, 255));
                    add_cmd(REQ_SAVE, now, ns, key, 1'($urandom_range(0, 1)), val, 1'b0);
                end
                else if (r < 85)
                    add_cmd(REQ_TICK, now, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), val,
                            $urandom_range(0, 32) == 0);
                else if (r < 93)
                    add_cmd(REQ_FLUSH, now, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), val, 1'b0);
                else if (r < 97)
                begin
                    // dropped by the block; does not count toward the total
                    add_cmd(REQ_NONE, $urandom(), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), val, 1'b0);
                    counted--;
                end
                else
                    // clock jump, possibly backwards: huge wrapped ages
                    add_cmd(REQ_TICK, $urandom(), 8'h00, 8'h00, 1'b0, 32'h0, 1'b0);
                counted++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver: pops the stimulus queue and drives start/cmd or cfg_valid
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {DRV_FETCH, DRV_WAIT, DRV_CMD, DRV_CFG} drv_state_e;

    drv_state_e drv_state;
    stim_t      cur_stim;
    int         gap_left;
    bit         drv_done = 1'b0;
    int         idle_run = 0;   // cycles with no word outstanding, from the monitor

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            cmd       <= '0;
            cfg_valid <= 1'b0;
            cfg_data  <= '0;
            drv_state = DRV_FETCH;
            gap_left  = 0;
        end
        else
        begin
            case (drv_state)
                DRV_FETCH:
                begin
                    drv_done <= (stim_q.size() == 0);
                    if (stim_q.size() > 0)
                    begin
                        cur_stim  = stim_q.pop_front();
                        gap_left  = cur_stim.gap;
                        drv_state = DRV_WAIT;
                    end
                end
                DRV_WAIT:
                begin
                    // a draining word waits for the block to go fully quiet
                    if (cur_stim.drain && (idle_run < SETTLE || busy))
                        gap_left = gap_left;
                    else if (gap_left > 0)
                        gap_left--;
                    else if (cur_stim.is_cfg)
                    begin
                        cfg_valid <= 1'b1;
                        cfg_data  <= cur_stim.cfg_word;
                        drv_state = DRV_CFG;
                    end
                    else
                    begin
                        start     <= 1'b1;
                        cmd       <= cur_stim.word;
                        drv_state = DRV_CMD;
                    end
                end
                DRV_CMD:
                begin
                    // taken at this edge when busy was low
                    if (!busy)
                    begin
                        // zero-gap follow-on command keeps start high
                        if (stim_q.size() > 0 && !stim_q[0].is_cfg && !stim_q[0].drain
                            && stim_q[0].gap == 0)
                        begin
                            cur_stim = stim_q.pop_front();
                            cmd <= cur_stim.word;
                        end
                        else
                        begin
                            start     <= 1'b0;
                            drv_state = DRV_FETCH;
                        end
                    end
                end
                default:
                begin
                    if (cfg_ready)
                    begin
                        cfg_valid <= 1'b0;
                        drv_state = DRV_FETCH;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // slot-table predictor
    // ------------------------------------------------------------------
    bit          tbl_used  [SLOTS];
    bit          tbl_pend  [SLOTS];
    logic [7:0]  tbl_ns    [SLOTS];
    logic [7:0]  tbl_key   [SLOTS];
    logic        tbl_kind  [SLOTS];
    logic [31:0] tbl_val   [SLOTS];
    logic [31:0] tbl_stamp [SLOTS];
    logic [15:0] quiet_ms;

    result_t due_results[$];    // expected result words, oldest first

    // run statistics
    int n_cmds;
    int n_status [3];
    int n_ticks;
    int n_flushes;
    int n_ignored;
    int n_writes;
    int n_checked;
    int n_settings;
    int mismatches = 0;

    task automatic clear_table();
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                tbl_used[i] = 1'b0;
                tbl_pend[i] = 1'b0;
            end
            quiet_ms = QUIET_RESET;
        end
    endtask

    task automatic predict_coalescer(input cmd_t c);
        result_t     outs [SLOTS];
        logic [1:0]  status;
        logic [31:0] age;
        int          hit;
        int          free_idx;
        int          n;
        bit          due;
        begin
            hit = -1;
            free_idx = -1;
            n = 0;
            n_cmds++;
            case (c.req_type)
                REQ_SAVE:
                begin
                    // a match anywhere beats the first free slot
                    for (int i = 0; i < SLOTS; i++)
                        if (tbl_used[i])
                        begin
                            if (hit < 0 && tbl_ns[i] == c.ns_id && tbl_key[i] == c.key_id)
                                hit = i;
                        end
                        else if (free_idx < 0)
                            free_idx = i;
                    if (hit >= 0)
                        status = SAVE_UPDATED;
                    else if (free_idx >= 0)
                    begin
                        hit = free_idx;
                        status = SAVE_ALLOC;
                        tbl_used[hit] = 1'b1;
                        tbl_ns[hit]   = c.ns_id;
                        tbl_key[hit]  = c.key_id;
                    end
                    else
                        status = SAVE_FULL;
                    if (hit >= 0)
                    begin
                        tbl_kind[hit]  = c.value_kind;
                        tbl_val[hit]   = c.data_value;
                        tbl_stamp[hit] = c.now_ms;
                        tbl_pend[hit]  = 1'b1;
                    end
                    n_status[status]++;
                    outs[0] = '0;
                    outs[0].result_kind = RK_STATUS;
                    outs[0].save_status = status;
                    n = 1;
                end
                REQ_TICK, REQ_FLUSH:
                begin
                    if (c.req_type == REQ_TICK)
                        n_ticks++;
                    else
                        n_flushes++;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        due = tbl_pend[i];
                        if (due && c.req_type == REQ_TICK)
                        begin
                            age = c.now_ms - tbl_stamp[i];
                            due = age > {16'h0, quiet_ms};
                        end
                        if (due)
                        begin
                            tbl_pend[i] = 1'b0;
                            outs[n] = '0;
                            outs[n].result_kind = RK_WRITE;
                            outs[n].out_ns_id   = tbl_ns[i];
                            outs[n].out_key_id  = tbl_key[i];
                            outs[n].out_kind    = tbl_kind[i];
                            outs[n].out_value   = tbl_val[i];
                            n++;
                        end
                    end
                    n_writes += n;
                end
                default:
                    n_ignored++;
            endcase
            for (int i = 0; i < n; i++)
            begin
                outs[i].last_result = (i == n - 1);
                due_results.push_back(outs[i]);
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
        begin
            $display("%0t MISMATCH %s: got %0h, expected %0h (word %0d)",
                     $realtime, what, got, exp, n_checked);
            mismatches++;
        end
    endtask

    task automatic check_word(input result_t got, input result_t exp);
        begin
            if (got.result_kind !== exp.result_kind)
                flag_mismatch("result_kind", 64'(got.result_kind), 64'(exp.result_kind));
            if (got.save_status !== exp.save_status)
                flag_mismatch("save_status", 64'(got.save_status), 64'(exp.save_status));
            if (got.out_ns_id !== exp.out_ns_id)
                flag_mismatch("out_ns_id", 64'(got.out_ns_id), 64'(exp.out_ns_id));
            if (got.out_key_id !== exp.out_key_id)
                flag_mismatch("out_key_id", 64'(got.out_key_id), 64'(exp.out_key_id));
            if (got.out_kind !== exp.out_kind)
                flag_mismatch("out_kind", 64'(got.out_kind), 64'(exp.out_kind));
            if (got.out_value !== exp.out_value)
                flag_mismatch("out_value", 64'($unsigned(got.out_value)),
                              64'($unsigned(exp.out_value)));
            if (got.last_result !== exp.last_result)
                flag_mismatch("last_result", 64'(got.last_result), 64'(exp.last_result));
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: checks result words, then feeds accepted words to the
    // predictor. Results of a word never show at the edge that takes it,
    // so check-then-predict in one block keeps the order fixed.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_table();
            idle_run <= 0;
        end
        else
        begin
            if (result_strobe === 1'b1)
            begin
                if (due_results.size() == 0)
                    flag_mismatch("unexpected result word", 64'(result), 64'h0);
                else
                    check_word(result, due_results.pop_front());
                n_checked++;
            end
            if (start && !busy)
                predict_coalescer(cmd);
            if (cfg_valid && cfg_ready)
            begin
                quiet_ms = cfg_data;
                n_settings++;
            end
            if ((start && !busy) || due_results.size() != 0)
                idle_run <= 0;
            else if (idle_run < 1000)
                idle_run <= idle_run + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequencing and end of run
    // ------------------------------------------------------------------
    initial
    begin
        build_directed();
        build_random();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // all words sent, nothing outstanding, and the block quiet a while
        while (!(drv_done && idle_run >= SETTLE))
            @(posedge clk);
        @(negedge clk);
        $display("Run covered %0d commands: saves %0d updated / %0d allocated / %0d full,",
                 n_cmds, n_status[0], n_status[1], n_status[2]);
        $display("  %0d ticks, %0d flushes, %0d dropped codes, %0d writes, %0d quiet settings",
                 n_ticks, n_flushes, n_ignored, n_writes, n_settings);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog, many times the slowest legal run
    initial
    begin
        #1_000_000;
        $display("Timeout: %0d result words still expected", due_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
sv/dwc_pkg.sv
sv/dwc_slot_ram.sv
sv/deferred_write_coalescer.sv
tb/tb_top.sv
